[sv/pms_pkg.sv]
`timescale 1ns / 1ps

package pms_pkg;

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 20;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COUNTING_MODE   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BAND_LOWER_SIZE = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CURRENT_LIMIT   = 2'd2;

   localparam logic [12:0] TIMEOUT_COUNTING_MS = 13'd5000;
   localparam logic [12:0] TIMEOUT_NORMAL_MS   = 13'd3500;
   localparam logic [12:0] BLANK_MS            = 13'd150;
   localparam logic [8:0]  STALL_WINDOW_MS     = 9'd400;
   localparam logic [7:0]  STALL_MIN_COUNTS    = 8'd3;
   localparam logic [1:0]  OVERCURRENT_HITS    = 2'd3;
   localparam logic [1:0]  FAULT_LIMIT         = 2'd2;

   typedef enum logic [2:0] {
      ST_RUNNING     = 3'd0,
      ST_REACHED     = 3'd1,
      ST_TIMEOUT     = 3'd2,
      ST_OVERCURRENT = 3'd3,
      ST_STALL       = 3'd4,
      ST_FAULT       = 3'd5,
      ST_ABORTED     = 3'd6,
      ST_IDLE        = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      DRV_NONE      = 3'd0,
      DRV_UP_SLOW   = 3'd1,
      DRV_UP_NORMAL = 3'd2,
      DRV_DOWN      = 3'd3,
      DRV_UP_FAST   = 3'd4
   } drive_type;

   typedef struct packed {
      logic               func;
      logic               move_down;
      logic signed [31:0] target_count;
      logic signed [31:0] encoder_count;
      logic [15:0]        current_sample;
      logic               upper_fault;
      logic               lower_fault;
      logic               stop_request;
   } req_type;

   typedef struct packed {
      status_type status;
      logic       stop_motor;
      drive_type  drive_command;
      logic       clear_faults;
   } rsp_type;

   typedef struct packed {
      logic        counting_mode;
      logic [19:0] band_lower_size;
      logic [15:0] current_limit;
   } cfg_type;

   typedef struct packed {
      logic               moving;
      logic               direction_down;
      logic signed [31:0] target_reg;
      logic signed [31:0] start_count;
      logic [12:0]        elapsed_ms;
      logic [8:0]         stall_timer_ms;
      logic signed [31:0] stall_ref_count;
      logic [1:0]         overcurrent_hits;
      logic [1:0]         fault_count;
      logic               fast_switched;
   } state_type;

endpackage

[sv/poster_move_supervisor_top.sv]
`timescale 1ns / 1ps
// An accepted transaction passes through one input register and then one result
// register before its result is valid; a stall on the response side can hold it
// in the input register.
// Throughput: one transaction per cycle while rsp_stall is low; while a result
// waits, the input register can still take one new item, and req_stall holds it.
// Reset is synchronous and active high; it clears the move state, the valid
// flags and the configuration registers to their default values.

module poster_move_supervisor_top import pms_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_type                    rsp_data,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic      in_valid_ff;
   logic      in_valid_in;
   req_type   in_data_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_data_ff;
   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   state_type state_ff;
   state_type state_in;
   state_type step_state;
   rsp_type   step_rsp;
   logic      advance;
   logic      fire;

   pms_step u_step (
      .cfg      (cfg_ff),
      .state    (state_ff),
      .req      (in_data_ff),
      .state_in (step_state),
      .rsp      (step_rsp)
   );

   always_comb begin
      advance      = !rsp_valid_ff || !rsp_stall;
      fire         = in_valid_ff && advance;
      req_stall    = in_valid_ff && !advance;
      in_valid_in  = req_stall ? in_valid_ff : req_valid;
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
      state_in     = fire ? step_state : state_ff;
      cfg_in       = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_COUNTING_MODE:   cfg_in.counting_mode   = csr_wdata[0];
            CSR_BAND_LOWER_SIZE: cfg_in.band_lower_size = csr_wdata[19:0];
            CSR_CURRENT_LIMIT:   cfg_in.current_limit   = csr_wdata[15:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
         cfg_ff       <= '{counting_mode: 1'b1, band_lower_size: 20'd0,
                           current_limit: 16'hFFFF};
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   property p_start_arms;
      @(posedge clock) disable iff (reset)
         (fire && in_data_ff.func == FUNC_START) |=> state_ff.moving;
   endproperty
   assert property (p_start_arms) else $error("start transaction did not arm the move");

   property p_abort_stops;
      @(posedge clock) disable iff (reset)
         (fire && in_data_ff.func == FUNC_TICK && in_data_ff.stop_request)
         |=> !state_ff.moving;
   endproperty
   assert property (p_abort_stops) else $error("stop request left the move running");

   property p_idle_quiet;
      @(posedge clock) disable iff (reset)
         (fire && in_data_ff.func == FUNC_TICK && !state_ff.moving)
         |=> (rsp_data_ff.status == ST_IDLE && !rsp_data_ff.stop_motor
              && rsp_data_ff.drive_command == DRV_NONE);
   endproperty
   assert property (p_idle_quiet) else $error("idle tick produced an action");

   property p_clear_only_on_retry;
      @(posedge clock) disable iff (reset)
         (rsp_valid_ff && rsp_data_ff.clear_faults)
         |-> (rsp_data_ff.stop_motor && (rsp_data_ff.status == ST_RUNNING
              || rsp_data_ff.status == ST_REACHED));
   endproperty
   assert property (p_clear_only_on_retry) else $error("fault clear outside a retry");

endmodule

[sv/pms_step.sv]
`timescale 1ns / 1ps

module pms_step import pms_pkg::*; (
   input  cfg_type   cfg,
   input  state_type state,
   input  req_type   req,
   output state_type state_in,
   output rsp_type   rsp
);

   logic signed [34:0] enc_x;
   logic signed [34:0] aenc;
   logic signed [34:0] fast_threshold;
   logic signed [34:0] tgt_x;
   logic signed [34:0] stall_diff;
   logic signed [34:0] stall_adiff;
   logic [12:0]        elapsed_inc;
   logic [8:0]         stall_inc;
   logic [1:0]         oc_inc;
   logic [1:0]         fault_inc;
   logic [12:0]        timeout_limit;
   logic               reached;
   logic               fast_hit;
   logic               oc_sample;
   logic               oc_trip;
   logic               stall_due;
   logic               stall_still;
   drive_type          start_drive;

   always_comb begin
      enc_x          = 35'(req.encoder_count);
      aenc           = enc_x[34] ? -enc_x : enc_x;
      fast_threshold = 35'(state.start_count)
                       + $signed({14'd0, cfg.band_lower_size, 1'b0});
      tgt_x          = 35'(state.target_reg);
      stall_diff     = enc_x - 35'(state.stall_ref_count);
      stall_adiff    = stall_diff[34] ? -stall_diff : stall_diff;
      elapsed_inc    = (state.elapsed_ms == '1) ? state.elapsed_ms
                                                : state.elapsed_ms + 13'd1;
      stall_inc      = (state.stall_timer_ms == '1) ? state.stall_timer_ms
                                                    : state.stall_timer_ms + 9'd1;
      oc_inc         = (state.overcurrent_hits == '1) ? state.overcurrent_hits
                                                      : state.overcurrent_hits + 2'd1;
      fault_inc      = (state.fault_count == '1) ? state.fault_count
                                                 : state.fault_count + 2'd1;
      timeout_limit  = cfg.counting_mode ? TIMEOUT_COUNTING_MS : TIMEOUT_NORMAL_MS;
      reached        = state.direction_down ? (aenc <= tgt_x) : (aenc >= tgt_x);
      fast_hit       = cfg.counting_mode && !state.fast_switched
                       && (aenc >= fast_threshold);
      oc_sample      = (req.current_sample > cfg.current_limit)
                       && (elapsed_inc >= BLANK_MS);
      oc_trip        = cfg.counting_mode && oc_sample && (oc_inc >= OVERCURRENT_HITS);
      stall_due      = cfg.counting_mode && (stall_inc >= STALL_WINDOW_MS);
      stall_still    = stall_adiff <= $signed({27'd0, STALL_MIN_COUNTS});
      start_drive    = state.direction_down ? DRV_DOWN
                       : (cfg.counting_mode ? DRV_UP_SLOW : DRV_UP_NORMAL);
   end

   always_comb begin
      state_in          = state;
      rsp.status        = ST_RUNNING;
      rsp.stop_motor    = 1'b0;
      rsp.drive_command = DRV_NONE;
      rsp.clear_faults  = 1'b0;
      if (req.func == FUNC_START) begin
         state_in.moving           = 1'b1;
         state_in.direction_down   = req.move_down;
         state_in.target_reg       = req.target_count;
         state_in.overcurrent_hits = '0;
         state_in.fault_count      = '0;
         state_in.start_count      = req.encoder_count;
         state_in.stall_ref_count  = req.encoder_count;
         state_in.elapsed_ms       = '0;
         state_in.stall_timer_ms   = '0;
         state_in.fast_switched    = 1'b0;
         rsp.drive_command = req.move_down ? DRV_DOWN
                             : (cfg.counting_mode ? DRV_UP_SLOW : DRV_UP_NORMAL);
      end else if (!state.moving) begin
         rsp.status = ST_IDLE;
      end else if (req.stop_request) begin
         state_in.moving = 1'b0;
         rsp.status      = ST_ABORTED;
         rsp.stop_motor  = 1'b1;
      end else begin
         state_in.elapsed_ms     = elapsed_inc;
         state_in.stall_timer_ms = stall_inc;
         if (elapsed_inc >= timeout_limit) begin
            state_in.moving = 1'b0;
            rsp.status      = ST_TIMEOUT;
            rsp.stop_motor  = 1'b1;
         end else begin
            if (fast_hit) begin
               state_in.fast_switched = 1'b1;
               rsp.drive_command      = DRV_UP_FAST;
            end
            if (cfg.counting_mode) begin
               state_in.overcurrent_hits = oc_sample ? oc_inc : 2'd0;
            end
            if (oc_trip) begin
               state_in.moving   = 1'b0;
               rsp.status        = ST_OVERCURRENT;
               rsp.stop_motor    = 1'b1;
               rsp.drive_command = DRV_NONE;
            end else if (req.upper_fault || req.lower_fault) begin
               state_in.fault_count = fault_inc;
               rsp.stop_motor       = 1'b1;
               if (fault_inc >= FAULT_LIMIT) begin
                  state_in.moving   = 1'b0;
                  rsp.status        = ST_FAULT;
                  rsp.drive_command = DRV_NONE;
               end else begin
                  state_in.start_count     = req.encoder_count;
                  state_in.stall_ref_count = req.encoder_count;
                  state_in.elapsed_ms      = '0;
                  state_in.stall_timer_ms  = '0;
                  state_in.fast_switched   = 1'b0;
                  rsp.clear_faults         = 1'b1;
                  if (reached) begin
                     state_in.moving   = 1'b0;
                     rsp.status        = ST_REACHED;
                     rsp.drive_command = DRV_NONE;
                  end else begin
                     rsp.drive_command = start_drive;
                  end
               end
            end else begin
               if (stall_due) begin
                  state_in.stall_timer_ms = '0;
                  if (!stall_still) begin
                     state_in.stall_ref_count = req.encoder_count;
                  end
               end
               if (stall_due && stall_still) begin
                  state_in.moving   = 1'b0;
                  rsp.status        = ST_STALL;
                  rsp.stop_motor    = 1'b1;
                  rsp.drive_command = DRV_NONE;
               end else if (reached) begin
                  state_in.moving   = 1'b0;
                  rsp.status        = ST_REACHED;
                  rsp.stop_motor    = 1'b1;
                  rsp.drive_command = DRV_NONE;
               end
            end
         end
      end
   end

endmodule
